// ===== design/pgt_pkg.sv =====
// shared item type, constants and output rounding for the polar gaussian transform
package pgt_pkg;

    localparam logic [31:0] SIGMA_RESET = 32'h0100_0000;
    localparam logic [31:0] HALF32      = 32'h8000_0000;
    localparam logic [31:0] TWO_LN2_HI  = 32'hB172_17F7;
    localparam logic [31:0] TWO_LN2_LO  = 32'hD1CF_79AC;
    localparam int          LOG_CELLS   = 58;
    localparam int          NORM_CELLS  = 6;
    localparam int          DIV_CELLS   = 33;
    localparam int          SQRT_CELLS  = 32;

    typedef struct packed {
        logic        neg_a;
        logic        neg_b;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [5:0]  k;
        logic [5:0]  z;
        logic        gzero;
        logic [7:0]  e;
        logic [6:0]  r;
        logic [63:0] w;
        logic [63:0] acc;
        logic [32:0] rem;
        logic [31:0] mh;
    } item_t;

    function automatic logic [31:0] round_sat(input logic [96:0] sum, input logic [6:0] r,
                                              input logic neg);
        logic [96:0] sh;
        logic [31:0] lim;
        logic [31:0] res;
        sh  = sum >> r;
        lim = neg ? HALF32 : (HALF32 - 32'd1);
        res = (sh[96:32] != '0 || sh[31:0] > lim) ? lim : sh[31:0];
        return neg ? (32'd0 - res) : res;
    endfunction

endpackage

// ===== design/pgt_norm_cell.sv =====
// normalizing cell: shifts the working word left by a fixed power of two when its top is clear
module pgt_norm_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [2:0]     sh_log,
    input  logic           in_vld,
    input  pgt_pkg::item_t in_item,
    output logic           out_vld,
    output pgt_pkg::item_t out_item
);
    logic           vld_reg;
    pgt_pkg::item_t item_reg;
    pgt_pkg::item_t item_next;
    logic [6:0]     amt;

    always_comb begin
        amt       = 7'd1 << sh_log;
        item_next = in_item;
        if ((in_item.w >> (7'd64 - amt)) == 64'd0) begin
            item_next.w = in_item.w << amt;
            item_next.z = in_item.z + amt[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;
endmodule

// ===== design/pgt_log_cell.sv =====
// log2 cell: squares the mantissa over two stages and yields one fraction bit
module pgt_log_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [5:0]     bit_idx,
    input  logic           in_vld,
    input  pgt_pkg::item_t in_item,
    output logic           out_vld,
    output pgt_pkg::item_t out_item
);
    logic           p_vld_reg;
    pgt_pkg::item_t p_item_reg;
    logic [61:0]    hh_reg;
    logic [62:0]    hl_reg;
    logic [63:0]    ll_reg;
    logic [61:0]    hh_next;
    logic [62:0]    hl_next;
    logic [63:0]    ll_next;
    logic [30:0]    x1;
    logic [31:0]    x0;
    logic           vld_reg;
    pgt_pkg::item_t item_reg;
    pgt_pkg::item_t item_next;
    logic [127:0]   sq;
    logic [63:0]    t;

    always_comb begin
        x1      = in_item.w[62:32];
        x0      = in_item.w[31:0];
        hh_next = 62'(x1) * 62'(x1);
        hl_next = 63'(x1) * 63'(x0);
        ll_next = 64'(x0) * 64'(x0);
    end

    always_comb begin
        sq = {2'd0, hh_reg, 64'd0} + {32'd0, hl_reg, 33'd0} + {64'd0, ll_reg};
        t  = sq[125:62];
        item_next = p_item_reg;
        if (t[63]) begin
            item_next.w   = t >> 1;
            item_next.acc = p_item_reg.acc | (64'd1 << bit_idx);
        end else begin
            item_next.w   = t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end else if (en) begin
            p_vld_reg <= in_vld;
            vld_reg   <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_item_reg <= in_item;
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            ll_reg     <= ll_next;
            item_reg   <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;
endmodule

// ===== design/pgt_div_cell.sv =====
// restoring divider cell: one quotient bit of the working word over the mantissa
module pgt_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [5:0]     bit_idx,
    input  logic           in_vld,
    input  pgt_pkg::item_t in_item,
    output logic           out_vld,
    output pgt_pkg::item_t out_item
);
    logic           vld_reg;
    pgt_pkg::item_t item_reg;
    pgt_pkg::item_t item_next;
    logic [32:0]    t;
    logic [32:0]    d;

    always_comb begin
        t         = {in_item.rem[31:0], in_item.w[bit_idx]};
        d         = {1'b0, in_item.mh};
        item_next = in_item;
        if (t >= d) begin
            item_next.rem          = t - d;
            item_next.acc[bit_idx] = 1'b1;
        end else begin
            item_next.rem          = t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;
endmodule

// ===== design/pgt_sqrt_cell.sv =====
// square root cell: one result bit of the digit by digit integer root
module pgt_sqrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [5:0]     bit_idx,
    input  logic           in_vld,
    input  pgt_pkg::item_t in_item,
    output logic           out_vld,
    output pgt_pkg::item_t out_item
);
    logic           vld_reg;
    pgt_pkg::item_t item_reg;
    pgt_pkg::item_t item_next;
    logic [63:0]    bitv;
    logic [63:0]    t;

    always_comb begin
        bitv      = 64'd1 << bit_idx;
        t         = in_item.acc + bitv;
        item_next = in_item;
        if (in_item.w >= t) begin
            item_next.w   = in_item.w - t;
            item_next.acc = (in_item.acc >> 1) + bitv;
        end else begin
            item_next.acc = in_item.acc >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;
endmodule

// ===== design/polar_gaussian_transform_top.sv =====
// top level of the polar gaussian transform: front end, cell chains and output scaling
// Takes one pair of uniform Q0.32 fractions per cycle and returns a pair of normal
// samples in signed Q8.24, scaled by sigma and saturated; a pair on or outside the
// unit circle or at its center gives no beat. Every stage is a register and the whole
// chain moves together, so one beat enters per cycle. Its stages: 3 front stages, two
// 6-cell normalizers, 58 log2 squaring cells of 2 stages each, 3 stages for the ln 2
// product, 33 divider cells, 32 square root cells, 4 scaling stages and 3 setup stages.
// A stall on the result side holds the whole chain. sigma is to be written through
// cfg_wr_en/cfg_wr_data only while no beat is in flight; the block does not check it.
module polar_gaussian_transform_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // uniform_a, uniform_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // normal_a, normal_b
);
    localparam int NC = pgt_pkg::NORM_CELLS;
    localparam int LC = pgt_pkg::LOG_CELLS;
    localparam int DC = pgt_pkg::DIV_CELLS;
    localparam int SC = pgt_pkg::SQRT_CELLS;

    logic        en;
    logic [31:0] sigma_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [63:0] m_tdata_next;

    // front
    logic        f1_vld_reg, f1_neg_a_reg, f1_neg_b_reg;
    logic [31:0] f1_mag_a_reg, f1_mag_b_reg;
    logic [31:0] ua, ub;
    logic        f2_vld_reg, f2_neg_a_reg, f2_neg_b_reg;
    logic [31:0] f2_mag_a_reg, f2_mag_b_reg;
    logic [63:0] f2_sq_a_reg, f2_sq_b_reg;
    logic [63:0] s_sum;
    logic        f3_vld_reg, f3_vld_next;
    pgt_pkg::item_t f3_item_reg, f3_item_next;

    // chains
    logic           n1vld [0:NC];
    pgt_pkg::item_t n1it  [0:NC];
    logic           p0_vld_reg;
    pgt_pkg::item_t p0_item_reg, p0_item_next;
    logic           lvld  [0:LC];
    pgt_pkg::item_t lit   [0:LC];
    logic           m0_vld_reg;
    pgt_pkg::item_t m0_item_reg, m0_item_next;
    logic           m1_vld_reg;
    pgt_pkg::item_t m1_item_reg;
    logic [63:0]    m1_p11_reg, m1_p10_reg, m1_p01_reg, m1_p00_reg;
    logic [127:0]   m_prod;
    logic           m2_vld_reg;
    pgt_pkg::item_t m2_item_reg, m2_item_next;
    logic           n2vld [0:NC];
    pgt_pkg::item_t n2it  [0:NC];
    logic           d0_vld_reg;
    pgt_pkg::item_t d0_item_reg, d0_item_next;
    logic           dvld  [0:DC];
    pgt_pkg::item_t dit   [0:DC];
    logic           q0_vld_reg;
    pgt_pkg::item_t q0_item_reg, q0_item_next;
    logic [33:0]    q_adj;
    logic [7:0]     e_adj;
    logic [7:0]     r_full;
    logic           qvld  [0:SC];
    pgt_pkg::item_t qit   [0:SC];

    // scaling
    logic        s1_vld_reg, s1_neg_a_reg, s1_neg_b_reg, s1_gzero_reg;
    logic [6:0]  s1_r_reg;
    logic [31:0] s1_root_reg;
    logic [63:0] s1_pa_reg, s1_pb_reg;
    logic        s2_vld_reg, s2_neg_a_reg, s2_neg_b_reg, s2_gzero_reg;
    logic [6:0]  s2_r_reg;
    logic [63:0] s2_ahi_reg, s2_alo_reg, s2_bhi_reg, s2_blo_reg;
    logic        s3_vld_reg, s3_neg_a_reg, s3_neg_b_reg, s3_gzero_reg;
    logic [6:0]  s3_r_reg;
    logic [96:0] s3_suma_reg, s3_sumb_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign ua       = s_tdata[31:0];
    assign ub       = s_tdata[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= pgt_pkg::SIGMA_RESET;
        end else if (cfg_wr_en) begin
            sigma_reg <= cfg_wr_data;
        end
    end

    // front end combinational
    always_comb begin
        s_sum        = f2_sq_a_reg + f2_sq_b_reg;
        f3_vld_next  = f2_vld_reg && (s_sum != 64'd0) && (s_sum[63:62] == 2'b00);
        f3_item_next = '0;
        f3_item_next.neg_a = f2_neg_a_reg;
        f3_item_next.neg_b = f2_neg_b_reg;
        f3_item_next.mag_a = f2_mag_a_reg;
        f3_item_next.mag_b = f2_mag_b_reg;
        f3_item_next.w     = {s_sum[62:0], 1'b0};
    end

    assign n1vld[0] = f3_vld_reg;
    assign n1it[0]  = f3_item_reg;

    // mantissa setup
    always_comb begin
        p0_item_next     = n1it[NC];
        p0_item_next.k   = 6'd62 - n1it[NC].z;
        p0_item_next.mh  = n1it[NC].w[63:32];
        p0_item_next.w   = {1'b0, n1it[NC].w[63:1]};
        p0_item_next.acc = 64'd0;
    end

    assign lvld[0] = p0_vld_reg;
    assign lit[0]  = p0_item_reg;

    // -log2 s and the ln 2 product
    always_comb begin
        m0_item_next   = lit[LC];
        m0_item_next.w = {lit[LC].z, 58'd0} - lit[LC].acc;
    end

    always_comb begin
        m_prod = {m1_p11_reg, 64'd0} + {32'd0, m1_p10_reg, 32'd0}
               + {32'd0, m1_p01_reg, 32'd0} + {64'd0, m1_p00_reg};
        m2_item_next       = m1_item_reg;
        m2_item_next.w     = m_prod[127:64];
        m2_item_next.z     = 6'd0;
        m2_item_next.gzero = (m_prod[127:64] == 64'd0);
    end

    assign n2vld[0] = m2_vld_reg;
    assign n2it[0]  = m2_item_reg;

    // divider setup
    always_comb begin
        d0_item_next     = n2it[NC];
        d0_item_next.rem = {2'd0, n2it[NC].w[63:33]};
        d0_item_next.acc = 64'd0;
        d0_item_next.e   = 8'd36 - {2'd0, n2it[NC].z} - {2'd0, n2it[NC].k};
    end

    assign dvld[0] = d0_vld_reg;
    assign dit[0]  = d0_item_reg;

    // root setup
    always_comb begin
        q_adj  = dit[DC].e[0] ? {dit[DC].acc[32:0], 1'b0} : {1'b0, dit[DC].acc[32:0]};
        e_adj  = dit[DC].e - {7'd0, dit[DC].e[0]} - 8'd28;
        r_full = 8'd31 - 8'($signed(e_adj) >>> 1);
        q0_item_next     = dit[DC];
        q0_item_next.w   = {2'd0, q_adj, 28'd0};
        q0_item_next.acc = 64'd0;
        q0_item_next.r   = r_full[6:0];
    end

    assign qvld[0] = q0_vld_reg;
    assign qit[0]  = q0_item_reg;

    always_comb begin
        m_tdata_next = 64'd0;
        if (!s3_gzero_reg) begin
            m_tdata_next = {pgt_pkg::round_sat(s3_sumb_reg, s3_r_reg, s3_neg_b_reg),
                            pgt_pkg::round_sat(s3_suma_reg, s3_r_reg, s3_neg_a_reg)};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++) begin : g_norm
            pgt_norm_cell u_n1 (
                .aclk(aclk), .aresetn(aresetn), .en(en), .sh_log(3'(NC - 1 - gi)),
                .in_vld(n1vld[gi]), .in_item(n1it[gi]),
                .out_vld(n1vld[gi+1]), .out_item(n1it[gi+1])
            );
            pgt_norm_cell u_n2 (
                .aclk(aclk), .aresetn(aresetn), .en(en), .sh_log(3'(NC - 1 - gi)),
                .in_vld(n2vld[gi]), .in_item(n2it[gi]),
                .out_vld(n2vld[gi+1]), .out_item(n2it[gi+1])
            );
        end
        for (gi = 0; gi < LC; gi++) begin : g_log
            pgt_log_cell u_log (
                .aclk(aclk), .aresetn(aresetn), .en(en), .bit_idx(6'(LC - 1 - gi)),
                .in_vld(lvld[gi]), .in_item(lit[gi]),
                .out_vld(lvld[gi+1]), .out_item(lit[gi+1])
            );
        end
        for (gi = 0; gi < DC; gi++) begin : g_div
            pgt_div_cell u_div (
                .aclk(aclk), .aresetn(aresetn), .en(en), .bit_idx(6'(DC - 1 - gi)),
                .in_vld(dvld[gi]), .in_item(dit[gi]),
                .out_vld(dvld[gi+1]), .out_item(dit[gi+1])
            );
        end
        for (gi = 0; gi < SC; gi++) begin : g_sqrt
            pgt_sqrt_cell u_sqrt (
                .aclk(aclk), .aresetn(aresetn), .en(en), .bit_idx(6'(62 - 2 * gi)),
                .in_vld(qvld[gi]), .in_item(qit[gi]),
                .out_vld(qvld[gi+1]), .out_item(qit[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg   <= 1'b0;
            f2_vld_reg   <= 1'b0;
            f3_vld_reg   <= 1'b0;
            p0_vld_reg   <= 1'b0;
            m0_vld_reg   <= 1'b0;
            m1_vld_reg   <= 1'b0;
            m2_vld_reg   <= 1'b0;
            d0_vld_reg   <= 1'b0;
            q0_vld_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg   <= s_tvalid;
            f2_vld_reg   <= f1_vld_reg;
            f3_vld_reg   <= f3_vld_next;
            p0_vld_reg   <= n1vld[NC];
            m0_vld_reg   <= lvld[LC];
            m1_vld_reg   <= m0_vld_reg;
            m2_vld_reg   <= m1_vld_reg;
            d0_vld_reg   <= n2vld[NC];
            q0_vld_reg   <= dvld[DC];
            s1_vld_reg   <= qvld[SC];
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            m_tvalid_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_neg_a_reg <= ~ua[31];
            f1_neg_b_reg <= ~ub[31];
            f1_mag_a_reg <= ua[31] ? {1'b0, ua[30:0]} : (pgt_pkg::HALF32 - ua);
            f1_mag_b_reg <= ub[31] ? {1'b0, ub[30:0]} : (pgt_pkg::HALF32 - ub);
            f2_neg_a_reg <= f1_neg_a_reg;
            f2_neg_b_reg <= f1_neg_b_reg;
            f2_mag_a_reg <= f1_mag_a_reg;
            f2_mag_b_reg <= f1_mag_b_reg;
            f2_sq_a_reg  <= 64'(f1_mag_a_reg) * 64'(f1_mag_a_reg);
            f2_sq_b_reg  <= 64'(f1_mag_b_reg) * 64'(f1_mag_b_reg);
            f3_item_reg  <= f3_item_next;
            p0_item_reg  <= p0_item_next;
            m0_item_reg  <= m0_item_next;
            m1_item_reg  <= m0_item_reg;
            m1_p11_reg   <= 64'(m0_item_reg.w[63:32]) * 64'(pgt_pkg::TWO_LN2_HI);
            m1_p10_reg   <= 64'(m0_item_reg.w[63:32]) * 64'(pgt_pkg::TWO_LN2_LO);
            m1_p01_reg   <= 64'(m0_item_reg.w[31:0]) * 64'(pgt_pkg::TWO_LN2_HI);
            m1_p00_reg   <= 64'(m0_item_reg.w[31:0]) * 64'(pgt_pkg::TWO_LN2_LO);
            m2_item_reg  <= m2_item_next;
            d0_item_reg  <= d0_item_next;
            q0_item_reg  <= q0_item_next;
            s1_neg_a_reg <= qit[SC].neg_a;
            s1_neg_b_reg <= qit[SC].neg_b;
            s1_gzero_reg <= qit[SC].gzero;
            s1_r_reg     <= qit[SC].r;
            s1_root_reg  <= qit[SC].acc[31:0];
            s1_pa_reg    <= 64'(qit[SC].mag_a) * 64'(sigma_reg);
            s1_pb_reg    <= 64'(qit[SC].mag_b) * 64'(sigma_reg);
            s2_neg_a_reg <= s1_neg_a_reg;
            s2_neg_b_reg <= s1_neg_b_reg;
            s2_gzero_reg <= s1_gzero_reg;
            s2_r_reg     <= s1_r_reg;
            s2_ahi_reg   <= 64'(s1_pa_reg[63:32]) * 64'(s1_root_reg);
            s2_alo_reg   <= 64'(s1_pa_reg[31:0]) * 64'(s1_root_reg);
            s2_bhi_reg   <= 64'(s1_pb_reg[63:32]) * 64'(s1_root_reg);
            s2_blo_reg   <= 64'(s1_pb_reg[31:0]) * 64'(s1_root_reg);
            s3_neg_a_reg <= s2_neg_a_reg;
            s3_neg_b_reg <= s2_neg_b_reg;
            s3_gzero_reg <= s2_gzero_reg;
            s3_r_reg     <= s2_r_reg;
            s3_suma_reg  <= {1'b0, s2_ahi_reg, 32'd0} + {33'd0, s2_alo_reg}
                            + (97'd1 << (s2_r_reg - 7'd1));
            s3_sumb_reg  <= {1'b0, s2_bhi_reg, 32'd0} + {33'd0, s2_blo_reg}
                            + (97'd1 << (s2_r_reg - 7'd1));
            m_tdata_reg  <= m_tdata_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_reject_center: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && f2_vld_reg && s_sum == 64'd0) |=> !f3_vld_reg)
        else $error("pair at the center not dropped");
    a_log_mant: assert property (@(posedge aclk) disable iff (!aresetn)
        lvld[LC] |-> (lit[LC].w[63:62] == 2'b01))
        else $error("log2 mantissa left [1,2)");
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        dvld[DC] |-> (dit[DC].rem < {1'b0, dit[DC].mh}))
        else $error("divider remainder not below divisor");
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q0_vld_reg |-> (q0_item_reg.r >= 7'd27 && q0_item_reg.r <= 7'd89))
        else $error("output shift out of range");
`endif
endmodule

// ===== tb/pgt_checker.sv =====
// checker for the polar gaussian transform: watches both channels, predicts and compares
module pgt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          pending,
    output int          errors
);
    localparam logic [63:0] TWO_LN2 = {pgt_pkg::TWO_LN2_HI, pgt_pkg::TWO_LN2_LO};

    typedef struct packed {
        logic [31:0] normal_b;
        logic [31:0] normal_a;
    } normal_pair_t;

    logic [31:0]  sigma_q;
    normal_pair_t normal_q[$];

    assign pending = normal_q.size();

    function automatic logic [63:0] mant_log2(input logic [63:0] m);
        logic [127:0] sq;
        logic [63:0]  acc;
        acc = '0;
        for (int i = 57; i >= 0; i--) begin
            sq = m * m;
            m = sq[125:62];
            if (m[63]) begin
                m = m >> 1;
                acc[i] = 1'b1;
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] q);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > q) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (q >= res + bitv) begin
                q = q - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] scale_sample(input logic neg, input logic [31:0] mag,
                                                 input logic [63:0] root, input int r);
        logic [128:0] prod;
        logic [128:0] sh;
        logic [31:0]  lim;
        logic [31:0]  res;
        lim = neg ? pgt_pkg::HALF32 : pgt_pkg::HALF32 - 32'd1;
        prod = ({64'd0, mag} * {32'd0, sigma_q}) * root;
        if (r < 1) begin
            res = (prod != 0) ? lim : 32'd0;
        end else if (r > 120) begin
            res = 32'd0;
        end else begin
            prod = prod + (129'd1 << (r - 1));
            sh = prod >> r;
            res = (sh > lim) ? lim : sh[31:0];
        end
        return neg ? 32'd0 - res : res;
    endfunction

    // returns 0 for a rejected pair
    function automatic bit gaussian_pair(input logic [31:0] ua, input logic [31:0] ub,
                                         output normal_pair_t np);
        logic         neg_a, neg_b;
        logic [31:0]  ma, mb;
        logic [63:0]  s, mant, lg, g, mh, q, root;
        logic [127:0] wide;
        int           k, z, e;
        neg_a = ua < pgt_pkg::HALF32;
        neg_b = ub < pgt_pkg::HALF32;
        ma = neg_a ? pgt_pkg::HALF32 - ua : ua - pgt_pkg::HALF32;
        mb = neg_b ? pgt_pkg::HALF32 - ub : ub - pgt_pkg::HALF32;
        s = {32'd0, ma} * {32'd0, ma} + {32'd0, mb} * {32'd0, mb};
        np = '0;
        if (s == 0 || s >= 64'h4000_0000_0000_0000) return 0;
        k = 0;
        while ((s >> (k + 1)) != 0) k++;
        mant = s << (62 - k);
        lg = (64'(62 - k) << 58) - mant_log2(mant);
        wide = {64'd0, lg} * {64'd0, TWO_LN2};
        g = wide[127:64];
        if (g == 0) return 1;
        z = 0;
        while (!g[63]) begin
            g = g << 1;
            z++;
        end
        mh = mant >> 31;
        q = g / mh;
        e = 36 - z - k;
        if (e % 2 != 0) begin
            q = q << 1;
            e = e - 1;
        end
        q = q << 28;
        e = e - 28;
        root = floor_sqrt(q);
        np.normal_a = scale_sample(neg_a, ma, root, 31 - e / 2);
        np.normal_b = scale_sample(neg_b, mb, root, 31 - e / 2);
        return 1;
    endfunction

    always @(posedge aclk) begin
        normal_pair_t np, got;
        int           nerr;
        nerr = 0;
        if (!aresetn) begin
            sigma_q <= pgt_pkg::SIGMA_RESET;
            normal_q.delete();
            errors <= 0;
        end else begin
            if (cfg_wr_en) sigma_q <= cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (gaussian_pair(s_tdata[31:0], s_tdata[63:32], np)) normal_q.push_back(np);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (normal_q.size() == 0) begin
                    $error("unexpected beat: %h", m_tdata);
                    nerr++;
                end else begin
                    np = normal_q.pop_front();
                    if (got.normal_a !== np.normal_a) begin
                        $error("normal_a expected %h actual %h", np.normal_a, got.normal_a);
                        nerr++;
                    end
                    if (got.normal_b !== np.normal_b) begin
                        $error("normal_b expected %h actual %h", np.normal_b, got.normal_b);
                        nerr++;
                    end
                end
            end
            errors <= errors + nerr;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the polar gaussian transform: stimulus, stalls and verdict
module tb_top;
    localparam int LATENCY = 206;
    localparam int LIMIT   = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [63:0] m_tdata;
    int          pending;
    int          errors;
    int          cycles = 0;
    int          burst_left;
    int          stall_mode = 0;

    polar_gaussian_transform_top dut (.*);

    pgt_checker chk (.*);

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls: modes change now and then, one of them never stalls
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = $urandom_range(0, 3) != 0;
            2: m_tready = $urandom_range(0, 1) != 0;
            default: m_tready = (cycles % 7) < 2;
        endcase
    end

    task automatic send_pair(input logic [31:0] ua, input logic [31:0] ub);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid = 1'b1;
        s_tdata = {ub, ua};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left--;
    endtask

    task automatic drain_and_set_sigma(input logic [31:0] val);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 40) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_pairs(input int n);
        logic [31:0] ua, ub;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                ua = pgt_pkg::HALF32
                     + ($urandom() >> $urandom_range(1, 31)) * ($urandom_range(0, 1) ? 1 : -1);
                ub = pgt_pkg::HALF32
                     + ($urandom() >> $urandom_range(1, 31)) * ($urandom_range(0, 1) ? 1 : -1);
            end else begin
                ua = $urandom();
                ub = $urandom();
            end
            send_pair(ua, ub);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        burst_left = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed beats at reset sigma
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(pgt_pkg::HALF32, pgt_pkg::HALF32);
        send_pair(pgt_pkg::HALF32 + 1, pgt_pkg::HALF32);
        send_pair(pgt_pkg::HALF32, pgt_pkg::HALF32 - 1);
        send_pair(32'hFFFF_FFFF, pgt_pkg::HALF32);
        send_pair(32'h0000_0001, pgt_pkg::HALF32);
        send_pair(pgt_pkg::HALF32, 32'hC000_0000);
        send_pair(32'h4000_0000, pgt_pkg::HALF32);
        send_pair(32'hDA82_7999, 32'hDA82_7999);
        send_pair(32'h2000_0000, 32'hE000_0000);
        send_pair(32'h0000_0001, 32'h8000_0001);
        drain_and_set_sigma(32'hFFFF_FFFF);
        send_pair(pgt_pkg::HALF32 + 1, pgt_pkg::HALF32 + 1);
        send_pair(pgt_pkg::HALF32 - 1, pgt_pkg::HALF32);
        send_pair(32'hA000_0000, 32'h6000_0000);
        send_pair(32'h0000_0001, pgt_pkg::HALF32);
        drain_and_set_sigma(32'h0000_0000);
        send_pair(32'hA000_0000, 32'h6000_0000);
        send_pair(pgt_pkg::HALF32 + 5, pgt_pkg::HALF32 - 3);

        random_pairs(300);
        drain_and_set_sigma(32'hFFFF_FFFF);
        random_pairs(350);
        drain_and_set_sigma($urandom());
        random_pairs(350);
        drain_and_set_sigma(32'h0000_0001);
        random_pairs(300);
        drain_and_set_sigma(pgt_pkg::SIGMA_RESET);
        random_pairs(450);

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 40) @(negedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/pgt_pkg.sv
design/pgt_norm_cell.sv
design/pgt_log_cell.sv
design/pgt_div_cell.sv
design/pgt_sqrt_cell.sv
design/polar_gaussian_transform_top.sv
tb/pgt_checker.sv
tb/tb_top.sv
